[rtl/cmdf_pkg.sv]
// ----------------------------------------------------------------------------
// cmdf_pkg
// Shared types, constants and coefficient table of the complex mix
// decimating FIR.
// ----------------------------------------------------------------------------
`default_nettype none

package cmdf_pkg;

  localparam int unsigned TapCount      = 31;
  localparam int unsigned TapIdxW       = 5;
  localparam int unsigned CoefW         = 13;
  localparam int unsigned SampleW       = 16;
  localparam int unsigned ProdW         = SampleW + CoefW;
  localparam int unsigned AccW          = 32;
  localparam int unsigned DecimationDef = 16;
  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned FracBits      = 15;

  typedef struct packed {
    logic signed [SampleW-1:0] adc_re;
    logic signed [SampleW-1:0] adc_im;
    logic signed [SampleW-1:0] lo_re;
    logic signed [SampleW-1:0] lo_im;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_re;
    logic signed [SampleW-1:0] out_im;
  } out_t;

  // mixed sample plus the decimation mark
  typedef struct packed {
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
    logic                      emit;
  } mix_t;

  // symmetric Q15 low-pass, unity gain
  function automatic logic signed [CoefW-1:0] tap_coef(input logic [TapIdxW-1:0] idx);
    logic signed [CoefW-1:0] c;
    case (idx)
      5'd0, 5'd30:  c = 13'sd115;
      5'd1, 5'd29:  c = 13'sd137;
      5'd2, 5'd28:  c = 13'sd192;
      5'd3, 5'd27:  c = 13'sd281;
      5'd4, 5'd26:  c = 13'sd405;
      5'd5, 5'd25:  c = 13'sd560;
      5'd6, 5'd24:  c = 13'sd743;
      5'd7, 5'd23:  c = 13'sd945;
      5'd8, 5'd22:  c = 13'sd1159;
      5'd9, 5'd21:  c = 13'sd1373;
      5'd10, 5'd20: c = 13'sd1578;
      5'd11, 5'd19: c = 13'sd1763;
      5'd12, 5'd18: c = 13'sd1919;
      5'd13, 5'd17: c = 13'sd2036;
      5'd14, 5'd16: c = 13'sd2110;
      5'd15:        c = 13'sd2136;
      default:      c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/cmdf_front.sv]
// ----------------------------------------------------------------------------
// cmdf_front
// Accepts input transactions, mixes the sample with the conjugate oscillator
// value and marks every DECIMATION-th sample for a filter output.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdf_front #(
  parameter int unsigned DECIMATION = cmdf_pkg::DecimationDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cmdf_pkg::in_t in_data_i,
  output logic               push_valid_o,
  input  wire logic          push_ready_i,
  output cmdf_pkg::mix_t     push_data_o
);

  localparam int unsigned PhW = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  logic [PhW-1:0] phase_q, phase_d;
  logic           last_phase;
  logic           accept;

  logic signed [31:0] p_rr, p_ii, p_ir, p_ri;
  logic        [32:0] re_sum, im_sum;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i & push_ready_i;
  assign last_phase   = (phase_q == PhW'(DECIMATION - 1));

  always_comb begin
    p_rr   = in_data_i.adc_re * in_data_i.lo_re;
    p_ii   = in_data_i.adc_im * in_data_i.lo_im;
    p_ir   = in_data_i.adc_im * in_data_i.lo_re;
    p_ri   = in_data_i.adc_re * in_data_i.lo_im;
    re_sum = {p_rr[31], p_rr} + {p_ii[31], p_ii};
    im_sum = {p_ir[31], p_ir} - {p_ri[31], p_ri};
    push_data_o.re   = re_sum[30:15];
    push_data_o.im   = im_sum[30:15];
    push_data_o.emit = last_phase;
  end

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = last_phase ? '0 : phase_q + PhW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

[rtl/cmdf_queue.sv]
// ----------------------------------------------------------------------------
// cmdf_queue
// Small FIFO between the mixer front end and the filter back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdf_queue #(
  parameter int unsigned DEPTH = cmdf_pkg::QueueDepthDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire cmdf_pkg::mix_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output cmdf_pkg::mix_t      pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmdf_pkg::mix_t entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/cmdf_back.sv]
// ----------------------------------------------------------------------------
// cmdf_back
// History ring and shared complex MAC; runs the 31-tap convolution when a
// marked sample arrives and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmdf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pop_valid_i,
  output logic                pop_ready_o,
  input  wire cmdf_pkg::mix_t pop_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output cmdf_pkg::out_t      out_data_o
);

  localparam int unsigned IdxW = cmdf_pkg::TapIdxW;
  localparam int unsigned SW   = cmdf_pkg::SampleW;
  localparam int unsigned PW   = cmdf_pkg::ProdW;
  localparam int unsigned AW   = cmdf_pkg::AccW;
  localparam int unsigned FB   = cmdf_pkg::FracBits;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(cmdf_pkg::TapCount - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic signed [SW-1:0] hist_re [cmdf_pkg::TapCount];
  logic signed [SW-1:0] hist_im [cmdf_pkg::TapCount];
  logic [cmdf_pkg::TapCount-1:0] hvalid_q, hvalid_d;

  logic [IdxW-1:0] wp_q, wp_d, rp_q, rp_d, cnt_q, cnt_d;
  logic            pop, hist_wr, issue;

  logic signed [SW-1:0]              rd_re_q, rd_im_q;
  logic                              rd_ok_q;
  logic signed [cmdf_pkg::CoefW-1:0] tap_q;
  logic                              s1_q, s2_q;
  logic signed [PW-1:0]              prod_re_q, prod_im_q;
  logic signed [SW-1:0]              op_re, op_im;
  logic signed [AW-1:0]              acc_re_q, acc_im_q;
  logic                              acc_clr;

  logic           out_vld_q, out_vld_d, out_load;
  cmdf_pkg::out_t out_q;

  assign pop_ready_o = (state_q == ST_IDLE);
  assign pop         = pop_valid_i & pop_ready_o;
  assign hist_wr     = pop;
  assign issue       = (state_q == ST_RUN);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d  = state_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    cnt_d    = cnt_q;
    hvalid_d = hvalid_q;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          hvalid_d[wp_q] = 1'b1;
          wp_d = (wp_q == LastIdx) ? '0 : wp_q + IdxW'(1);
          if (pop_data_i.emit) begin
            rp_d    = wp_d;
            cnt_d   = '0;
            acc_clr = 1'b1;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        rp_d  = (rp_q == LastIdx) ? '0 : rp_q + IdxW'(1);
        cnt_d = cnt_q + IdxW'(1);
        if (cnt_q == LastIdx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_q && !s2_q) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // unwritten history slots read as zero
  assign op_re = rd_ok_q ? rd_re_q : '0;
  assign op_im = rd_ok_q ? rd_im_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      cnt_q     <= '0;
      hvalid_q  <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      cnt_q     <= cnt_d;
      hvalid_q  <= hvalid_d;
      s1_q      <= issue;
      s2_q      <= s1_q;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_wr) begin
      hist_re[wp_q] <= pop_data_i.re;
      hist_im[wp_q] <= pop_data_i.im;
    end
    if (issue) begin
      rd_re_q <= hist_re[rp_q];
      rd_im_q <= hist_im[rp_q];
      rd_ok_q <= hvalid_q[rp_q];
      tap_q   <= cmdf_pkg::tap_coef(cnt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      prod_re_q <= op_re * tap_q;
      prod_im_q <= op_im * tap_q;
    end
    if (acc_clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (s2_q) begin
      acc_re_q <= acc_re_q + {{(AW-PW){prod_re_q[PW-1]}}, prod_re_q};
      acc_im_q <= acc_im_q + {{(AW-PW){prod_im_q[PW-1]}}, prod_im_q};
    end
    if (out_load) begin
      out_q.out_re <= acc_re_q[FB+SW-1:FB];
      out_q.out_im <= acc_im_q[FB+SW-1:FB];
    end
  end

endmodule

`default_nettype wire

[rtl/complex_mix_decimating_fir.sv]
// ----------------------------------------------------------------------------
// complex_mix_decimating_fir
// Complex down-converter with a 31-tap decimating low-pass FIR.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction per raw
// complex sample with its oscillator value. The sample is mixed with the
// conjugate oscillator value on acceptance and queued; non-marked samples
// are accepted one per cycle while the queue has room.
// Output channel (out_valid_o/out_ready_i/out_data_o): one transaction for
// every DECIMATION-th input sample.
// Path from the marked input to out_valid_o with an empty queue: queue pop,
// one MAC issue per tap for all 31 taps on the shared multiplier pair,
// drain of the two pipeline stages, and the output load. Sustained
// throughput is set by the single MAC walking the history ring; it takes
// no new sample from the queue while a convolution runs.
// Reset clears the history (through per-slot valid bits), ring pointer,
// phase counter, queue and output valid flag.
// A stalled receiver holds the result in the output register; the MAC then
// waits before loading the next result and the queue fills behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_mix_decimating_fir #(
  parameter int unsigned DECIMATION  = cmdf_pkg::DecimationDef,
  parameter int unsigned QUEUE_DEPTH = cmdf_pkg::QueueDepthDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire cmdf_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output cmdf_pkg::out_t     out_data_o
);

  logic           push_valid, push_ready, pop_valid, pop_ready;
  cmdf_pkg::mix_t push_data, pop_data;

  cmdf_front #(
    .DECIMATION (DECIMATION)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  cmdf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  cmdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
